FILE: hw/rtl/ffba_pkg.sv
// Shared types and codes for the first-fit bank allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int ROWS_W   = 6;
  localparam int COLS_W   = 6;
  localparam int HANDLE_W = 5;
  localparam int BASE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 6;
  // full product of rows and cols
  localparam int NEED_W   = ROWS_W + COLS_W;
  // room for index + length sums and compares
  localparam int WIDE_W   = NEED_W + 1;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [ROWS_W-1:0]   rows;
    logic [COLS_W-1:0]   cols;
    logic [HANDLE_W-1:0] handle;
  } ffba_req_t;

  typedef struct packed {
    logic                ok;
    logic [BASE_W-1:0]   base_bank;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used_banks;
  } ffba_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fit;
    logic pick;
    logic commit;
  } ffba_ctrl_t;

endpackage

FILE: hw/rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ffba_ctrl.sv
// Sequencing state machine for the bank allocator.
`timescale 1ns / 1ps
module ffba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              cmd_i,
  output logic              busy,
  output ffba_pkg::ffba_ctrl_t ctrl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIT    = 2'd1;
  localparam logic [1:0] S_PICK   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       load;

  assign busy = (state_q != S_IDLE);
  assign load = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (load) begin
          // a release only waits for the size read
          state_d = (cmd_i == ffba_pkg::CMD_RELEASE) ? S_COMMIT : S_FIT;
        end
      end
      S_FIT:    state_d = S_PICK;
      S_PICK:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.load   = load;
  assign ctrl_o.fit    = (state_q == S_FIT);
  assign ctrl_o.pick   = (state_q == S_PICK);
  assign ctrl_o.commit = (state_q == S_COMMIT);

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> (state_q == S_IDLE))
    else $error("commit not followed by idle");

  a_release_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd_i == ffba_pkg::CMD_RELEASE) |=> (state_q == S_COMMIT))
    else $error("release did not go straight to commit");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy)
    else $error("accepted word did not raise busy");

endmodule

FILE: hw/rtl/ffba_datapath.sv
// Bank bitmap, handle table, run search and result register.
`timescale 1ns / 1ps
module ffba_datapath #(
  parameter int BANKS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffba_pkg::ffba_ctrl_t  ctrl_i,
  input  ffba_pkg::ffba_req_t   req_i,
  output ffba_pkg::ffba_rsp_t   rsp_o,
  output logic                  rsp_valid_o
);

  localparam int IDX_W  = $clog2(BANKS);
  localparam int CNT_W  = $clog2(BANKS + 1);
  localparam int NEED_W = ffba_pkg::NEED_W;
  localparam int WIDE_W = ffba_pkg::WIDE_W;

  logic [BANKS-1:0]              used_q, used_d;
  logic [BANKS-1:0]              live_q, live_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          cmd_q;
  logic [NEED_W-1:0]             need_q;
  logic [ffba_pkg::HANDLE_W-1:0] h_q;
  logic [BANKS-1:0]              fit_q, fit_d;
  logic [BANKS-1:0]              win_mask;
  logic [IDX_W-1:0]              start_q, pick_idx;
  logic                          found_q;
  ffba_pkg::ffba_rsp_t           rsp_q, rsp_d;
  logic                          rsp_valid_q;

  logic [CNT_W-1:0]  size_rd;
  logic              ram_we;
  logic [IDX_W-1:0]  h_idx;
  logic              h_ok;
  logic [WIDE_W-1:0] lo_w, len_w;
  logic [BANKS-1:0]  run_mask;

  // run length stored per live handle; read address follows the incoming word
  ffba_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BANKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (start_q),
    .wdata_i (CNT_W'(need_q)),
    .raddr_i (IDX_W'(req_i.handle)),
    .rdata_o (size_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= req_i.cmd;
      need_q <= NEED_W'(req_i.rows) * NEED_W'(req_i.cols);
      h_q    <= req_i.handle;
    end
    if (ctrl_i.fit) begin
      fit_q <= fit_d;
    end
    if (ctrl_i.pick) begin
      start_q <= pick_idx;
      found_q <= |fit_q;
    end
    if (ctrl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // window of need_q ones from bit 0
  always_comb begin
    for (int i = 0; i < BANKS; i++) begin
      win_mask[i] = WIDE_W'(i) < WIDE_W'(need_q);
    end
  end

  // a start fits when the window shifted down to it sees no used bank
  for (genvar s = 0; s < BANKS; s++) begin : g_fit
    logic [BANKS-1:0] tail;
    assign tail     = used_q >> s;
    assign fit_d[s] = ~|(tail & win_mask) &&
                      ((WIDE_W'(s) + WIDE_W'(need_q)) <= WIDE_W'(BANKS));
  end

  // lowest fitting start
  always_comb begin
    pick_idx = '0;
    for (int s = BANKS - 1; s >= 0; s--) begin
      if (fit_q[s]) begin
        pick_idx = IDX_W'(s);
      end
    end
  end

  assign h_idx = IDX_W'(h_q);
  assign h_ok  = (WIDE_W'(h_q) < WIDE_W'(BANKS)) && live_q[h_idx];

  // one range mask serves both marking and freeing
  always_comb begin
    if (cmd_q == ffba_pkg::CMD_RELEASE) begin
      lo_w  = WIDE_W'(h_q);
      len_w = WIDE_W'(size_rd);
    end else begin
      lo_w  = WIDE_W'(start_q);
      len_w = WIDE_W'(need_q);
    end
    for (int i = 0; i < BANKS; i++) begin
      run_mask[i] = (WIDE_W'(i) >= lo_w) && (WIDE_W'(i) < (lo_w + len_w));
    end
  end

  always_comb begin
    used_d            = used_q;
    live_d            = live_q;
    count_d           = count_q;
    ram_we            = 1'b0;
    rsp_d.ok          = 1'b0;
    rsp_d.base_bank   = '0;
    rsp_d.status      = ffba_pkg::ST_OK;
    if (cmd_q == ffba_pkg::CMD_ALLOC) begin
      if (need_q == '0) begin
        // empty request: granted at bank 0, nothing recorded
        rsp_d.ok = 1'b1;
      end else if (found_q) begin
        used_d          = used_q | run_mask;
        live_d[start_q] = 1'b1;
        count_d         = count_q + CNT_W'(need_q);
        ram_we          = ctrl_i.commit;
        rsp_d.ok        = 1'b1;
        rsp_d.base_bank = ffba_pkg::BASE_W'(start_q);
      end else begin
        rsp_d.status = ffba_pkg::ST_NO_FIT;
      end
    end else begin
      if (h_ok) begin
        used_d        = used_q & ~run_mask;
        live_d[h_idx] = 1'b0;
        count_d       = count_q - size_rd;
        rsp_d.ok      = 1'b1;
      end else begin
        rsp_d.status = ffba_pkg::ST_UNKNOWN;
      end
    end
    rsp_d.used_banks = ffba_pkg::USED_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      live_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= ctrl_i.commit;
      if (ctrl_i.commit) begin
        used_q  <= used_d;
        live_q  <= live_d;
        count_q <= count_d;
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(count_q))
    else $error("used count out of step with bitmap");

  a_live_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & ~used_q) == '0)
    else $error("live handle on a free bank");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.ok == (rsp_q.status == ffba_pkg::ST_OK)))
    else $error("ok flag disagrees with status");

endmodule

FILE: hw/rtl/first_fit_bank_allocator.sv
// Allocation passes the fit, pick and commit states from accept to the result strobe; release goes straight to commit.
// Allocate path: product at accept, parallel fit search, lowest-start pick, commit.
// Release path: handle size read from the size RAM at accept, then commit.
// A new word can be taken in the cycle the result strobe is shown.
// Reset clears the bitmap, live handles and count at once; the size RAM is not cleared.
// Results are shown for one cycle only; the receiver cannot stall them.
`timescale 1ns / 1ps
module first_fit_bank_allocator #(
  parameter int BANKS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ffba_pkg::ffba_req_t req_i,
  output logic                busy,
  output ffba_pkg::ffba_rsp_t rsp_o,
  output logic                rsp_valid_o
);

  ffba_pkg::ffba_ctrl_t ctrl;

  ffba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (req_i.cmd),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  ffba_datapath #(
    .BANKS (BANKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the first-fit bank allocator: directed and random words.
`timescale 1ns / 1ps
module tb_top;

  localparam int BANKS       = 32;
  localparam int N_RANDOM    = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int REQ_W       = $bits(ffba_pkg::ffba_req_t);

  // Tracks the bank bitmap and live handles, predicts each response and checks it.
  class bank_alloc_scoreboard;
    bit        bank_used   [BANKS];
    bit        handle_live [BANKS];
    bit [5:0]  handle_size [BANKS];
    ffba_pkg::ffba_rsp_t pending_rsp [$];
    int errors;
    int n_grant, n_zero, n_no_fit, n_freed, n_unknown;

    function int used_count();
      int n;
      n = 0;
      for (int i = 0; i < BANKS; i++) n += bank_used[i];
      return n;
    endfunction

    function void note_request(ffba_pkg::ffba_req_t word);
      ffba_pkg::ffba_rsp_t rsp;
      int need, first, s, i, h;
      bit fits;
      rsp = '0;
      if (word.cmd == ffba_pkg::CMD_ALLOC) begin
        need  = int'(word.rows) * int'(word.cols);
        first = -1;
        if (need == 0) begin
          // zero-size: granted at bank 0, nothing recorded
          rsp.ok     = 1'b1;
          rsp.status = ffba_pkg::ST_OK;
          n_zero++;
        end else begin
          if (need <= BANKS) begin
            for (s = 0; s + need <= BANKS && first < 0; s++) begin
              fits = 1'b1;
              for (i = 0; i < need; i++) if (bank_used[s + i]) fits = 1'b0;
              if (fits) first = s;
            end
          end
          if (first >= 0) begin
            for (i = 0; i < need; i++) bank_used[first + i] = 1'b1;
            handle_live[first] = 1'b1;
            handle_size[first] = need[5:0];
            rsp.ok        = 1'b1;
            rsp.base_bank = first[ffba_pkg::BASE_W-1:0];
            rsp.status    = ffba_pkg::ST_OK;
            n_grant++;
          end else begin
            rsp.status = ffba_pkg::ST_NO_FIT;
            n_no_fit++;
          end
        end
      end else begin
        h = int'(word.handle);
        if (!handle_live[h]) begin
          rsp.status = ffba_pkg::ST_UNKNOWN;
          n_unknown++;
        end else begin
          for (i = 0; i < handle_size[h]; i++)
            if (h + i < BANKS) bank_used[h + i] = 1'b0;
          handle_live[h] = 1'b0;
          rsp.ok     = 1'b1;
          rsp.status = ffba_pkg::ST_OK;
          n_freed++;
        end
      end
      rsp.used_banks = ffba_pkg::USED_W'(used_count());
      pending_rsp.push_back(rsp);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_response(ffba_pkg::ffba_rsp_t got);
      ffba_pkg::ffba_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none outstanding, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("ok",         8'(want.ok),         8'(got.ok));
        compare_field("base_bank",  8'(want.base_bank),  8'(got.base_bank));
        compare_field("status",     8'(want.status),     8'(got.status));
        compare_field("used_banks", 8'(want.used_banks), 8'(got.used_banks));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  ffba_pkg::ffba_req_t req_i;
  logic                busy;
  ffba_pkg::ffba_rsp_t rsp_o;
  logic                rsp_valid_o;

  bank_alloc_scoreboard alloc_sb = new();
  int words_sent;
  int stall_cycles;
  int last_freed;

  first_fit_bank_allocator #(.BANKS(BANKS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) alloc_sb.check_response(rsp_o);
  end

  // give up once nothing has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || rsp_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired at %0t with %0d responses outstanding",
                 $time, alloc_sb.pending_rsp.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic ffba_pkg::ffba_req_t alloc_word(int rows, int cols);
    ffba_pkg::ffba_req_t w;
    w.cmd    = ffba_pkg::CMD_ALLOC;
    w.rows   = rows[ffba_pkg::ROWS_W-1:0];
    w.cols   = cols[ffba_pkg::COLS_W-1:0];
    w.handle = ffba_pkg::HANDLE_W'($urandom());
    return w;
  endfunction

  function automatic ffba_pkg::ffba_req_t release_word(int h);
    ffba_pkg::ffba_req_t w;
    w.cmd    = ffba_pkg::CMD_RELEASE;
    w.rows   = ffba_pkg::ROWS_W'($urandom_range(32));
    w.cols   = ffba_pkg::COLS_W'($urandom_range(32));
    w.handle = h[ffba_pkg::HANDLE_W-1:0];
    return w;
  endfunction

  // called on a rising edge; returns on the edge that takes the word
  task automatic send_word(ffba_pkg::ffba_req_t w);
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    alloc_sb.note_request(w);
    words_sent++;
    if (w.cmd == ffba_pkg::CMD_RELEASE) last_freed = int'(w.handle);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    req_i <= REQ_W'($urandom());
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic int pick_live_handle();
    int live [$];
    for (int i = 0; i < BANKS; i++) if (alloc_sb.handle_live[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  task automatic directed_words();
    ffba_pkg::ffba_req_t seq [$];
    seq.push_back(alloc_word(0, 0));
    seq.push_back(alloc_word(0, 32));
    seq.push_back(alloc_word(32, 0));
    seq.push_back(alloc_word(32, 32));     // far over the bank count
    seq.push_back(alloc_word(3, 11));      // one over
    seq.push_back(release_word(0));        // nothing live yet
    seq.push_back(release_word(31));
    seq.push_back(alloc_word(1, 32));      // whole bitmap
    seq.push_back(alloc_word(1, 1));       // full, no fit
    seq.push_back(release_word(0));
    seq.push_back(alloc_word(4, 4));
    seq.push_back(alloc_word(2, 4));
    seq.push_back(alloc_word(1, 7));
    seq.push_back(alloc_word(1, 1));       // last bank
    seq.push_back(release_word(31));
    seq.push_back(alloc_word(1, 2));       // only one bank left
    seq.push_back(alloc_word(1, 1));
    seq.push_back(release_word(16));       // opens an 8-bank hole
    seq.push_back(alloc_word(3, 3));       // hole too small
    seq.push_back(alloc_word(2, 2));       // lands in the hole
    seq.push_back(release_word(16));
    seq.push_back(release_word(16));       // already retired
    seq.push_back(release_word(24));
    seq.push_back(release_word(0));
    seq.push_back(release_word(31));
    foreach (seq[i]) begin
      send_word(seq[i]);
      if ($urandom_range(99) < 12) hold_off($urandom_range(1, 5));
    end
  endtask

  task automatic random_words();
    int sel, h;
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99);
      h   = pick_live_handle();
      if (sel < 45 || (sel >= 53 && sel < 88 && h < 0))
        send_word(alloc_word($urandom_range(1, 3), $urandom_range(1, 6)));
      else if (sel < 50)
        send_word(alloc_word($urandom_range(32), $urandom_range(32)));
      else if (sel < 53)
        send_word($urandom_range(1) ? alloc_word(0, $urandom_range(32))
                                    : alloc_word($urandom_range(32), 0));
      else if (sel < 88)
        send_word(release_word(h));
      else if (sel < 96)
        send_word(release_word($urandom_range(BANKS - 1)));
      else
        send_word(release_word(last_freed));
      // a quiet stretch in the middle keeps words back to back
      if ((n < 700 || n > 1100) && $urandom_range(99) < 12) hold_off($urandom_range(1, 5));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    words_sent   = 0;
    stall_cycles = 0;
    last_freed   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    random_words();
    start <= 1'b0;
    while (alloc_sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words: %0d grants, %0d zero-size, %0d no-fit", words_sent,
             alloc_sb.n_grant, alloc_sb.n_zero, alloc_sb.n_no_fit);
    $display("Releases: %0d freed, %0d unknown handle; %0d mismatches", alloc_sb.n_freed,
             alloc_sb.n_unknown, alloc_sb.errors);
    if (alloc_sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_datapath.sv
hw/rtl/first_fit_bank_allocator.sv
tb/tb_top.sv
